/* hw/rtl/lru_page_frame_replacement_top_defines.svh */
// Assertion macros used by the LRU page frame replacement checker.
`ifndef LRU_PAGE_FRAME_REPLACEMENT_TOP_DEFINES_SVH
`define LRU_PAGE_FRAME_REPLACEMENT_TOP_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define LPFR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset.
`define LPFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/lpfr_pkg.sv */
// Package with widths, register codes and payload types of the LRU page frame block.
package lpfr_pkg;

   localparam int PAGE_W     = 16;
   localparam int SLOT_OUT_W = 4;
   localparam int COUNT_W    = 32;
   localparam int CFG_W      = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_FRAMES_IN_USE = 2'd0;
   localparam logic [CFG_W-1:0]      FRAMES_IN_USE_RESET    = 5'd16;
   localparam logic [COUNT_W-1:0]    COUNT_MAX              = '1;

   typedef struct packed {
      logic                  hit;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  evicted_valid;
      logic [PAGE_W-1:0]     evicted_page;
      logic [COUNT_W-1:0]    fault_count;
      logic [COUNT_W-1:0]    hit_count;
   } rsp_type;

endpackage

/* hw/rtl/lpfr_if.sv */
// Valid/ready channel interfaces for page references and replacement results.
interface lpfr_req_if import lpfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PAGE_W-1:0] page;

   modport source (output valid, output page, input ready);
   modport sink   (input valid, input page, output ready);
endinterface

interface lpfr_rsp_if import lpfr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [SLOT_OUT_W-1:0] slot;
   logic                  evicted_valid;
   logic [PAGE_W-1:0]     evicted_page;
   logic [COUNT_W-1:0]    fault_count;
   logic [COUNT_W-1:0]    hit_count;

   modport source (output valid, output hit, output slot, output evicted_valid,
                   output evicted_page, output fault_count, output hit_count,
                   input ready);
   modport sink   (input valid, input hit, input slot, input evicted_valid,
                   input evicted_page, input fault_count, input hit_count,
                   output ready);
endinterface

/* hw/rtl/lru_page_frame_replacement_top.sv */
// LRU page frame replacement: one page reference in, one hit/fault result out per transfer.
// Each reference is registered in the input register, then compared against all resident
// frames in parallel, the frame ranks are updated and the result is registered, so the
// block sustains one reference per clock while the output is not stalled. The search and
// re-rank over the frame registers are combinational, between the input and output
// registers, and a result stays in the output register until it transfers. frames_in_use
// (CSR byte address 0) limits how many frames are searched and replaced; 0 acts as 1 and
// values above FRAMES act as FRAMES. Write it only while no reference is in flight. Hit and
// fault counts saturate at 2^32-1.
module lru_page_frame_replacement_top import lpfr_pkg::*; #(
   parameter int FRAMES    = 16,
   parameter int PAGE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   lpfr_req_if.sink              req,
   lpfr_rsp_if.source            rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W = $clog2(FRAMES + 1);
   localparam logic [CNT_W-1:0] FRAMES_C  = CNT_W'(FRAMES);
   localparam logic [IDX_W:0]   RANK_NEW  = (IDX_W + 1)'(FRAMES);
   localparam logic [IDX_W:0]   RANK_TOP  = (IDX_W + 1)'(FRAMES - 1);

   // configuration
   logic [CFG_W-1:0] frames_ff;
   logic [CFG_W-1:0] frames_in;
   logic             csr_wr;
   logic [CNT_W-1:0] active_n;

   // frame state
   logic [PAGE_BITS-1:0] page_ff  [FRAMES];
   logic [IDX_W-1:0]     rank_ff  [FRAMES];
   logic [IDX_W-1:0]     rank_in  [FRAMES];
   logic [FRAMES-1:0]    valid_ff;
   logic [FRAMES-1:0]    valid_in;
   logic [CNT_W-1:0]     filled_ff;
   logic [CNT_W-1:0]     filled_in;
   logic [COUNT_W-1:0]   faults_ff;
   logic [COUNT_W-1:0]   faults_in;
   logic [COUNT_W-1:0]   hits_ff;
   logic [COUNT_W-1:0]   hits_in;

   // input and output registers
   logic                 in_vld_ff;
   logic [PAGE_BITS-1:0] in_page_ff;
   logic                 out_vld_ff;
   rsp_type              out_ff;
   rsp_type              out_in;
   logic                 advance;

   // lookup
   logic [FRAMES-1:0]    in_use;
   logic [FRAMES-1:0]    match;
   logic [FRAMES-1:0]    hit_oh;
   logic [FRAMES-1:0]    vic_oh;
   logic [FRAMES-1:0]    fill_oh;
   logic [FRAMES-1:0]    sel_oh;
   logic                 hit_any;
   logic                 fill;
   logic                 evict;
   logic [IDX_W-1:0]     slot_idx;
   logic [IDX_W:0]       old_rank;
   logic [PAGE_BITS-1:0] victim_pg;

   // ---------------- CSR ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr == CSR_ADDR_FRAMES_IN_USE);
   assign frames_in  = csr_wr ? csr_pwdata[CFG_W-1:0] : frames_ff;
   assign csr_prdata = (csr_paddr == CSR_ADDR_FRAMES_IN_USE)
                       ? CSR_DATA_W'(frames_ff) : '0;

   always_comb begin
      if (frames_ff == '0) begin
         active_n = CNT_W'(1);
      end else if (32'(frames_ff) > 32'(FRAMES)) begin
         active_n = FRAMES_C;
      end else begin
         active_n = CNT_W'(frames_ff);
      end
   end

   // ---------------- handshake ----------------
   assign advance   = in_vld_ff && (!out_vld_ff || rsp.ready);
   assign req.ready = !in_vld_ff || advance;

   // ---------------- lookup and re-rank ----------------
   always_comb begin
      logic hit_seen;
      hit_seen  = 1'b0;
      slot_idx  = '0;
      old_rank  = '0;
      victim_pg = '0;
      for (int i = 0; i < FRAMES; i++) begin
         in_use[i]  = CNT_W'(i) < active_n;
         match[i]   = in_use[i] && valid_ff[i] && (page_ff[i] == in_page_ff);
         hit_oh[i]  = match[i] && !hit_seen;
         hit_seen   = hit_seen | match[i];
         fill_oh[i] = CNT_W'(i) == filled_ff;
      end
      hit_any = hit_seen;
      fill    = !hit_any && (filled_ff < active_n);
      evict   = !hit_any && !fill;

      // greatest rank wins, lowest frame on a tie
      for (int i = 0; i < FRAMES; i++) begin
         vic_oh[i] = in_use[i];
         for (int j = 0; j < FRAMES; j++) begin
            if (j != i && in_use[j]) begin
               if (j < i) begin
                  vic_oh[i] = vic_oh[i] & (rank_ff[j] < rank_ff[i]);
               end else begin
                  vic_oh[i] = vic_oh[i] & (rank_ff[j] <= rank_ff[i]);
               end
            end
         end
      end

      sel_oh = hit_any ? hit_oh : (fill ? fill_oh : vic_oh);

      for (int i = 0; i < FRAMES; i++) begin
         if (sel_oh[i]) begin
            slot_idx  = slot_idx | IDX_W'(i);
            old_rank  = old_rank | {1'b0, rank_ff[i]};
            victim_pg = victim_pg | page_ff[i];
         end
      end
      if (fill) begin
         old_rank = RANK_NEW;
      end

      for (int i = 0; i < FRAMES; i++) begin
         rank_in[i]  = rank_ff[i];
         valid_in[i] = valid_ff[i] | (sel_oh[i] & advance);
         if (sel_oh[i]) begin
            rank_in[i] = '0;
         end else if (valid_ff[i] && ({1'b0, rank_ff[i]} < old_rank)
                      && ({1'b0, rank_ff[i]} < RANK_TOP)) begin
            rank_in[i] = rank_ff[i] + 1'b1;
         end
      end

      filled_in = fill ? filled_ff + 1'b1 : filled_ff;
      hits_in   = (hit_any && hits_ff != COUNT_MAX) ? hits_ff + 1'b1 : hits_ff;
      faults_in = (!hit_any && faults_ff != COUNT_MAX) ? faults_ff + 1'b1 : faults_ff;

      out_in.hit           = hit_any;
      out_in.slot          = SLOT_OUT_W'(slot_idx);
      out_in.evicted_valid = evict;
      out_in.evicted_page  = evict ? PAGE_W'(victim_pg) : '0;
      out_in.fault_count   = faults_in;
      out_in.hit_count     = hits_in;
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff  <= FRAMES_IN_USE_RESET;
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         valid_ff   <= '0;
         filled_ff  <= '0;
         faults_ff  <= '0;
         hits_ff    <= '0;
      end else begin
         frames_ff <= frames_in;
         if (req.ready) begin
            in_vld_ff <= req.valid;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
            valid_ff   <= valid_in;
            filled_ff  <= filled_in;
            faults_ff  <= faults_in;
            hits_ff    <= hits_in;
         end else if (rsp.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_page_ff <= PAGE_BITS'(req.page);
      end
      if (advance) begin
         out_ff <= out_in;
         for (int i = 0; i < FRAMES; i++) begin
            rank_ff[i] <= rank_in[i];
            if (sel_oh[i]) begin
               page_ff[i] <= in_page_ff;
            end
         end
      end
   end

   assign rsp.valid         = out_vld_ff;
   assign rsp.hit           = out_ff.hit;
   assign rsp.slot          = out_ff.slot;
   assign rsp.evicted_valid = out_ff.evicted_valid;
   assign rsp.evicted_page  = out_ff.evicted_page;
   assign rsp.fault_count   = out_ff.fault_count;
   assign rsp.hit_count     = out_ff.hit_count;

endmodule

/* hw/rtl/lpfr_checker.sv */
// Port-level checks on the LRU page frame replacement top level, bound in below.
`include "lru_page_frame_replacement_top_defines.svh"

module lpfr_checker import lpfr_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_hit,
   input logic                  rsp_evicted_valid,
   input logic [PAGE_W-1:0]     rsp_evicted_page,
   input logic [COUNT_W-1:0]    rsp_fault_count,
   input logic [COUNT_W-1:0]    rsp_hit_count
);

   // a stalled result stays valid and keeps its evicted page and its counts
   `LPFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_evicted_page) && $stable(rsp_hit_count) && $stable(rsp_fault_count), "stalled result changed")

   // an eviction only happens on a fault
   `LPFR_ASSERT_IMPLY(a_evict_on_fault, clock, reset, rsp_valid, !(rsp_hit && rsp_evicted_valid), "eviction reported on a hit")

   `LPFR_ASSERT_IMPLY(a_evict_page_zero, clock, reset, rsp_valid && !rsp_evicted_valid, rsp_evicted_page == '0, "evicted page nonzero without eviction")

   // every result comes with a nonzero hit or fault count
   `LPFR_ASSERT_IMPLY(a_counted, clock, reset, rsp_valid, (rsp_fault_count != '0) || (rsp_hit_count != '0), "result not counted")

endmodule

bind lru_page_frame_replacement_top lpfr_checker u_lpfr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_hit           (rsp.hit),
   .rsp_evicted_valid (rsp.evicted_valid),
   .rsp_evicted_page  (rsp.evicted_page),
   .rsp_fault_count   (rsp.fault_count),
   .rsp_hit_count     (rsp.hit_count)
);
